>>> design/hfrc_pkg.sv
// Shared types, codes and constants of the HID frame reassembly controller.
// Used by the controller, the datapath, the top level and the checker.
package hfrc_pkg;

  localparam int NUM_CHANNELS_DEF = 4;
  localparam int FRAME_BYTES      = 64;
  localparam int INIT_PAYLOAD     = FRAME_BYTES - 7;
  localparam int CONT_PAYLOAD     = FRAME_BYTES - 5;
  localparam int BUF_BYTES        = 7609;
  localparam int LEN_W            = 13;
  localparam int CPY_W            = 6;
  localparam int SLOT_W           = 2;
  localparam int CFG_W            = 16;

  localparam logic [31:0] BCAST_ID      = 32'hFFFF_FFFF;
  localparam logic [6:0]  CMD_MASK      = 7'h7F;
  localparam logic [6:0]  CMD_INIT      = 7'h06;
  localparam logic [6:0]  CMD_SYNC      = 7'h3C;
  localparam logic [15:0] TIMEOUT_RESET = 16'd600;

  typedef enum logic [1:0] {
    MODE_FRAME = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_OPEN  = 2'd2,
    MODE_CLOSE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_INVALID_CHAN = 3'd1,
    ST_BUSY         = 3'd2,
    ST_INVALID_LEN  = 3'd3,
    ST_INVALID_SEQ  = 3'd4,
    ST_TIMEOUT      = 3'd5
  } status_e;

  typedef enum logic {
    CFG_TIMEOUT = 1'b0,
    CFG_MAX_LEN = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_LOOKUP = 2'd1,
    S_UPDATE = 2'd2
  } state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] chan_id_in;
    logic [7:0]  cmd_or_seq;
    logic [15:0] len_field;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [31:0]       chan_id_out;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  copy_offset;
    logic [CPY_W-1:0]  copy_len;
    logic              message_done;
    logic [7:0]        cmd_out;
    logic [LEN_W-1:0]  message_len;
  } result_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_result;
  } dp_status_t;

endpackage

>>> design/hid_frame_reassembly_controller_core.sv
// Top level of the HID frame reassembly controller.
// Depends on hfrc_pkg; instantiates hfrc_ctrl and hfrc_datapath.
//
// Usage: present a word on item_i and raise start_i while busy_o is low; the
// word is taken at that edge. mode selects a frame header check, a time tick,
// or a channel open or close. The block then looks the channel up in its
// table in a lookup step and decides and updates the table in an update step.
// A result word appears on result_o with result_valid_o high for exactly one
// cycle, registered after the update step; a tick that finds no timeout gives
// no result. The receiver has no way to hold results back.
// busy_o is high from an accept until the update step is done, so a new item
// is taken only once the last one has passed both steps. Configuration is
// written through cfg_we_i, cfg_idx_i and cfg_data_i (index 0 timeout in ms,
// index 1 largest message length) while the block is idle.
// Reset clears the channel table, sets the timeout to 600 ms and the length
// limit to 7609 bytes, and leaves the block idle.
module hid_frame_reassembly_controller_core import hfrc_pkg::*; #(
  parameter int NumChannels = NUM_CHANNELS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  item_t            item_i,
  output logic             result_valid_o,
  output result_t          result_o,
  input  logic             cfg_we_i,
  input  cfg_reg_e         cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  ctrl_cmd_t  dp_cmd;
  dp_status_t dp_status;

  hfrc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .dp_status_i    (dp_status),
    .dp_cmd_o       (dp_cmd),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o)
  );

  hfrc_datapath #(
    .NumChannels (NumChannels)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dp_cmd_i    (dp_cmd),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .dp_status_o (dp_status),
    .result_o    (result_o)
  );

endmodule

>>> design/hfrc_ctrl.sv
// Sequencing state machine of the HID frame reassembly controller.
// Depends on hfrc_pkg; drives the datapath through ctrl_cmd_t.
module hfrc_ctrl import hfrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t dp_status_i,
  output ctrl_cmd_t  dp_cmd_o,
  output logic       busy_o,
  output logic       result_valid_o
);

  state_e state_q, state_d;
  logic   valid_q, valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    dp_cmd_o = '0;
    valid_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          dp_cmd_o.capture = 1'b1;
          state_d          = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        dp_cmd_o.lookup = 1'b1;
        state_d         = S_UPDATE;
      end
      S_UPDATE: begin
        dp_cmd_o.update = 1'b1;
        valid_d         = dp_status_i.has_result;
        state_d         = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = valid_q;

endmodule

>>> design/hfrc_datapath.sv
// Channel table, configuration registers and decision logic of the controller.
// Depends on hfrc_pkg; sequenced by hfrc_ctrl.
module hfrc_datapath import hfrc_pkg::*; #(
  parameter int NumChannels = NUM_CHANNELS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        dp_cmd_i,
  input  item_t            item_i,
  input  logic             cfg_we_i,
  input  cfg_reg_e         cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output dp_status_t       dp_status_o,
  output result_t          result_o
);

  localparam int IdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  // Configuration.
  logic [15:0]      timeout_q;
  logic [LEN_W-1:0] max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      max_len_q <= LEN_W'(BUF_BYTES);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TIMEOUT: timeout_q <= cfg_data_i;
        CFG_MAX_LEN: max_len_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Channel table.
  logic             valid_q [NumChannels];
  logic             phase_q [NumChannels];
  logic [LEN_W-1:0] total_q [NumChannels];
  logic [LEN_W-1:0] off_q   [NumChannels];
  logic [7:0]       seq_q   [NumChannels];
  logic [31:0]      chan_q  [NumChannels];
  logic [7:0]       cmd_q   [NumChannels];
  logic [31:0]      last_q  [NumChannels];

  // Captured item and lookup results.
  item_t                  item_q;
  logic                   match_q, free_q, busy_q;
  logic [IdxW-1:0]        match_idx_q, free_idx_q, busy_idx_q;
  logic [NumChannels-1:0] expired_q, bcast_q;

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.capture) begin
      item_q <= item_i;
    end
  end

  logic                   match_d, free_d, busy_d;
  logic [IdxW-1:0]        match_idx_d, free_idx_d, busy_idx_d;
  logic [NumChannels-1:0] expired_d, bcast_d;

  // Lowest matching, lowest free and in-progress entry; per-entry timeout flags.
  always_comb begin
    match_d     = 1'b0;
    free_d      = 1'b0;
    busy_d      = 1'b0;
    match_idx_d = '0;
    free_idx_d  = '0;
    busy_idx_d  = '0;
    for (int i = NumChannels - 1; i >= 0; i--) begin
      if (valid_q[i] && chan_q[i] == item_q.chan_id_in) begin
        match_d     = 1'b1;
        match_idx_d = IdxW'(i);
      end
      if (!valid_q[i]) begin
        free_d     = 1'b1;
        free_idx_d = IdxW'(i);
      end
      if (valid_q[i] && phase_q[i]) begin
        busy_d     = 1'b1;
        busy_idx_d = IdxW'(i);
      end
      expired_d[i] = (item_q.now_ms - last_q[i]) > {16'd0, timeout_q};
      bcast_d[i]   = valid_q[i] && chan_q[i] == BCAST_ID;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.lookup) begin
      match_q     <= match_d;
      free_q      <= free_d;
      busy_q      <= busy_d;
      match_idx_q <= match_idx_d;
      free_idx_q  <= free_idx_d;
      busy_idx_q  <= busy_idx_d;
      expired_q   <= expired_d;
      bcast_q     <= bcast_d;
    end
  end

  // Decision and table update.
  result_t          res;
  logic             has_res;
  logic             upd_en, set_valid, clr_valid, wr_chan, wr_cmd, wr_last, wr_ctl;
  logic             free_bcast;
  logic [IdxW-1:0]  upd_idx, e;
  logic [31:0]      chan_val;
  logic [7:0]       cmd_val;
  logic             phase_val;
  logic [LEN_W-1:0] total_val, off_val, base_total, base_off, rem;
  logic [7:0]       seq_val, base_seq;
  logic [CPY_W-1:0] cp_len;
  logic             is_bc, is_init, resync, alloc, done;

  always_comb begin
    res         = '0;
    res.chan_id_out = item_q.chan_id_in;
    has_res     = 1'b1;
    upd_en      = 1'b0;
    upd_idx     = '0;
    set_valid   = 1'b0;
    clr_valid   = 1'b0;
    wr_chan     = 1'b0;
    wr_cmd      = 1'b0;
    wr_last     = 1'b0;
    wr_ctl      = 1'b0;
    free_bcast  = 1'b0;
    chan_val    = item_q.chan_id_in;
    cmd_val     = '0;
    phase_val   = 1'b0;
    total_val   = '0;
    off_val     = '0;
    seq_val     = '0;
    cp_len      = '0;
    rem         = '0;
    done        = 1'b0;
    is_bc       = item_q.chan_id_in == BCAST_ID;
    is_init     = item_q.cmd_or_seq[7] && item_q.cmd_or_seq[6:0] == CMD_INIT;
    resync      = busy_q && item_q.cmd_or_seq[7] &&
                  (item_q.cmd_or_seq[6:0] == CMD_INIT || item_q.cmd_or_seq[6:0] == CMD_SYNC);
    alloc       = is_bc && !match_q;
    e           = match_q ? match_idx_q : free_idx_q;
    base_total  = (alloc || resync) ? '0 : total_q[e];
    base_off    = (alloc || resync) ? '0 : off_q[e];
    base_seq    = (alloc || resync) ? '0 : seq_q[e];

    case (mode_e'(item_q.mode))
      MODE_FRAME: begin
        if (item_q.chan_id_in == '0) begin
          res.status = ST_INVALID_CHAN;
        end else if (!match_q && !is_bc) begin
          res.status = ST_BUSY;
        end else if (is_bc && !is_init) begin
          res.status = ST_INVALID_CHAN;
        end else if (alloc && !free_q) begin
          res.status = ST_BUSY;
        end else begin
          upd_en  = 1'b1;
          upd_idx = e;
          if (alloc) begin
            // A new broadcast entry starts idle with a cleared command.
            set_valid = 1'b1;
            wr_chan   = 1'b1;
            wr_cmd    = 1'b1;
            wr_last   = 1'b1;
            wr_ctl    = 1'b1;
          end
          if (busy_q && busy_idx_q != e) begin
            res.status = ST_BUSY;
          end else if (busy_q && !resync && expired_q[e]) begin
            wr_ctl     = 1'b1;
            res.status = ST_TIMEOUT;
          end else begin
            wr_last   = 1'b1;
            wr_ctl    = 1'b1;
            phase_val = 1'b1;
            total_val = base_total;
            off_val   = base_off;
            seq_val   = base_seq;
            if (base_total == '0) begin
              if (item_q.len_field > {3'd0, max_len_q} ||
                  item_q.len_field > 16'(BUF_BYTES)) begin
                res.status = ST_INVALID_LEN;
              end else begin
                total_val = item_q.len_field[LEN_W-1:0];
                seq_val   = '0;
                wr_cmd    = 1'b1;
                cmd_val   = item_q.cmd_or_seq;
                if (item_q.len_field <= 16'(INIT_PAYLOAD)) begin
                  cp_len = item_q.len_field[CPY_W-1:0];
                  done   = 1'b1;
                end else begin
                  cp_len = CPY_W'(INIT_PAYLOAD);
                end
                off_val          = {{(LEN_W-CPY_W){1'b0}}, cp_len};
                res.status       = ST_OK;
                res.slot         = SLOT_W'(e);
                res.copy_len     = cp_len;
                res.message_done = done;
                res.cmd_out      = item_q.cmd_or_seq;
                res.message_len  = total_val;
              end
            end else if (item_q.cmd_or_seq != base_seq || item_q.cmd_or_seq[7]) begin
              res.status = ST_INVALID_SEQ;
            end else if (base_off >= base_total) begin
              res.status = ST_INVALID_LEN;
            end else begin
              rem    = base_total - base_off;
              cp_len = (rem < LEN_W'(CONT_PAYLOAD)) ? rem[CPY_W-1:0] : CPY_W'(CONT_PAYLOAD);
              seq_val          = base_seq + 8'd1;
              off_val          = base_off + {{(LEN_W-CPY_W){1'b0}}, cp_len};
              done             = off_val >= base_total;
              res.status       = ST_OK;
              res.slot         = SLOT_W'(e);
              res.copy_offset  = base_off;
              res.copy_len     = cp_len;
              res.message_done = done;
              res.cmd_out      = cmd_q[e];
              res.message_len  = base_total;
            end
            if (done) begin
              // A finished message frees its message state and all broadcast entries.
              phase_val  = 1'b0;
              total_val  = '0;
              off_val    = '0;
              seq_val    = '0;
              free_bcast = 1'b1;
            end
          end
        end
      end
      MODE_TICK: begin
        if (busy_q && expired_q[busy_idx_q]) begin
          upd_en          = 1'b1;
          upd_idx         = busy_idx_q;
          wr_ctl          = 1'b1;
          res.status      = ST_TIMEOUT;
          res.chan_id_out = chan_q[busy_idx_q];
        end else begin
          has_res = 1'b0;
        end
      end
      MODE_OPEN: begin
        if (item_q.chan_id_in == '0 || is_bc) begin
          res.status = ST_INVALID_CHAN;
        end else if (match_q) begin
          res.status = ST_OK;
          res.slot   = SLOT_W'(match_idx_q);
        end else if (!free_q) begin
          res.status = ST_BUSY;
        end else begin
          upd_en     = 1'b1;
          upd_idx    = free_idx_q;
          set_valid  = 1'b1;
          wr_chan    = 1'b1;
          wr_cmd     = 1'b1;
          wr_last    = 1'b1;
          wr_ctl     = 1'b1;
          res.status = ST_OK;
          res.slot   = SLOT_W'(free_idx_q);
        end
      end
      default: begin
        if (match_q) begin
          upd_en     = 1'b1;
          upd_idx    = match_idx_q;
          clr_valid  = 1'b1;
          wr_ctl     = 1'b1;
          res.status = ST_OK;
          res.slot   = SLOT_W'(match_idx_q);
        end else begin
          res.status = ST_INVALID_CHAN;
        end
      end
    endcase
  end

  assign dp_status_o.has_result = has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) begin
        valid_q[i] <= 1'b0;
        phase_q[i] <= 1'b0;
        total_q[i] <= '0;
        off_q[i]   <= '0;
        seq_q[i]   <= '0;
      end
    end else if (dp_cmd_i.update) begin
      for (int i = 0; i < NumChannels; i++) begin
        if (free_bcast && (bcast_q[i] ||
            (set_valid && IdxW'(i) == upd_idx && chan_val == BCAST_ID))) begin
          valid_q[i] <= 1'b0;
          phase_q[i] <= 1'b0;
          total_q[i] <= '0;
          off_q[i]   <= '0;
          seq_q[i]   <= '0;
        end else if (upd_en && IdxW'(i) == upd_idx) begin
          if (set_valid) begin
            valid_q[i] <= 1'b1;
          end else if (clr_valid) begin
            valid_q[i] <= 1'b0;
          end
          if (wr_ctl) begin
            phase_q[i] <= phase_val;
            total_q[i] <= total_val;
            off_q[i]   <= off_val;
            seq_q[i]   <= seq_val;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.update) begin
      result_o <= res;
      for (int i = 0; i < NumChannels; i++) begin
        if (upd_en && IdxW'(i) == upd_idx) begin
          if (wr_chan) chan_q[i] <= chan_val;
          if (wr_cmd)  cmd_q[i]  <= cmd_val;
          if (wr_last) last_q[i] <= item_q.now_ms;
        end
      end
    end
  end

endmodule

>>> design/hfrc_checker.sv
// Port-level checks of the HID frame reassembly controller, bound to the top.
// Depends on hfrc_pkg.
module hfrc_checker import hfrc_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start_i,
  input logic    busy_o,
  input logic    result_valid_o,
  input result_t result_o
);

  // An accepted word keeps the block busy while it is worked on.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o ##1 busy_o)
    else $error("block not busy after accept");

  // A result only shows after a matching accept.
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, 3))
    else $error("result without matching accept");

  // A result word lasts a single cycle.
  a_result_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // Only successful frames carry a copy length.
  a_error_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status != ST_OK) |->
      (result_o.copy_len == '0 && result_o.message_done == 1'b0))
    else $error("error result carries payload fields");

endmodule

bind hid_frame_reassembly_controller_core hfrc_checker u_hfrc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

>>> test/hid_frame_reassembly_controller_core_tb.sv
// Testbench for the HID frame reassembly controller top level.
// Depends on hfrc_pkg; a scoreboard class predicts each result word from a
// model of the channel table and compares it with what the block produces.
`timescale 1ns / 1ps

module hid_frame_reassembly_controller_core_tb;
  import hfrc_pkg::*;

  localparam int NCH = NUM_CHANNELS_DEF;
  localparam longint CYCLE_LIMIT = 2000000;

  class reassembly_scoreboard;
    bit          ent_valid[NCH];
    logic [31:0] ent_id[NCH];
    bit          ent_active[NCH];
    logic [7:0]  ent_cmd[NCH];
    int unsigned ent_total[NCH];
    int unsigned ent_offset[NCH];
    logic [7:0]  ent_seq[NCH];
    logic [31:0] ent_stamp[NCH];
    int unsigned timeout_ms;
    int unsigned max_len;
    result_t     pending[$];
    int          errors;

    function void init();
      for (int i = 0; i < NCH; i++) begin
        ent_valid[i] = 0; ent_id[i] = 0; ent_cmd[i] = 0; ent_stamp[i] = 0;
        clear_msg(i);
      end
      timeout_ms = 600;
      max_len = BUF_BYTES;
      pending.delete();
      errors = 0;
    endfunction

    function void clear_msg(int i);
      ent_active[i] = 0; ent_total[i] = 0; ent_offset[i] = 0; ent_seq[i] = 0;
    endfunction

    function int lookup(logic [31:0] cid);
      for (int i = 0; i < NCH; i++)
        if (ent_valid[i] && ent_id[i] == cid) return i;
      return -1;
    endfunction

    function int free_entry();
      for (int i = 0; i < NCH; i++) if (!ent_valid[i]) return i;
      return -1;
    endfunction

    function int active_entry();
      for (int i = 0; i < NCH; i++) if (ent_valid[i] && ent_active[i]) return i;
      return -1;
    endfunction

    function void push(status_e st, logic [31:0] cid, int sl = 0, int off = 0,
                       int len = 0, bit done = 0, logic [7:0] cmd = 0,
                       int mlen = 0);
      result_t r;
      r.status = st; r.chan_id_out = cid; r.slot = sl[SLOT_W-1:0];
      r.copy_offset = off[LEN_W-1:0]; r.copy_len = len[CPY_W-1:0];
      r.message_done = done; r.cmd_out = cmd; r.message_len = mlen[LEN_W-1:0];
      pending.push_back(r);
    endfunction

    function void allocate(int e, logic [31:0] cid, logic [31:0] now);
      ent_valid[e] = 1; ent_id[e] = cid; ent_cmd[e] = 0; ent_stamp[e] = now;
      clear_msg(e);
    endfunction

    function void note_frame(item_t it);
      int act, e, off, len;
      bit done, is_cmd;
      logic [31:0] cid;
      logic [7:0] cb;
      cid = it.chan_id_in; cb = it.cmd_or_seq;
      act = active_entry();
      is_cmd = cb[7];
      if (cid == 0) begin push(ST_INVALID_CHAN, cid); return; end
      e = lookup(cid);
      if (e < 0 && cid != BCAST_ID) begin push(ST_BUSY, cid); return; end
      if (cid == BCAST_ID) begin
        if (!is_cmd || cb[6:0] != CMD_INIT) begin push(ST_INVALID_CHAN, cid); return; end
        if (e < 0) begin
          e = free_entry();
          if (e < 0) begin push(ST_BUSY, cid); return; end
          allocate(e, cid, it.now_ms);
        end
      end
      if (act >= 0) begin
        if (act != e) begin push(ST_BUSY, cid); return; end
        if (is_cmd && (cb[6:0] == CMD_INIT || cb[6:0] == CMD_SYNC)) clear_msg(e);
        else if (32'(it.now_ms - ent_stamp[e]) > timeout_ms) begin
          clear_msg(e);
          push(ST_TIMEOUT, cid);
          return;
        end
      end
      ent_active[e] = 1;
      ent_stamp[e] = it.now_ms;
      if (ent_total[e] == 0) begin
        if (it.len_field > max_len || it.len_field > BUF_BYTES) begin
          push(ST_INVALID_LEN, cid); return;
        end
        ent_total[e] = it.len_field; ent_seq[e] = 0; ent_cmd[e] = cb;
        off = 0; len = INIT_PAYLOAD; done = 0;
        if (it.len_field <= len) begin len = it.len_field; done = 1; end
        ent_offset[e] = len;
      end else begin
        if (cb != ent_seq[e] || cb[7]) begin push(ST_INVALID_SEQ, cid); return; end
        if (ent_offset[e] >= ent_total[e]) begin push(ST_INVALID_LEN, cid); return; end
        off = ent_offset[e];
        len = CONT_PAYLOAD;
        if (len > ent_total[e] - off) len = ent_total[e] - off;
        ent_seq[e] = ent_seq[e] + 8'd1;
        ent_offset[e] = off + len;
        done = ent_offset[e] >= ent_total[e];
      end
      push(ST_OK, cid, e, off, len, done, ent_cmd[e], ent_total[e]);
      if (done) begin
        clear_msg(e);
        for (int i = 0; i < NCH; i++)
          if (ent_valid[i] && ent_id[i] == BCAST_ID) begin
            ent_valid[i] = 0; clear_msg(i);
          end
      end
    endfunction

    function void note_input(item_t it);
      int e;
      case (mode_e'(it.mode))
        MODE_FRAME: note_frame(it);
        MODE_TICK: begin
          e = active_entry();
          if (e >= 0 && 32'(it.now_ms - ent_stamp[e]) > timeout_ms) begin
            clear_msg(e);
            push(ST_TIMEOUT, ent_id[e]);
          end
        end
        MODE_OPEN: begin
          if (it.chan_id_in == 0 || it.chan_id_in == BCAST_ID) begin
            push(ST_INVALID_CHAN, it.chan_id_in); return;
          end
          e = lookup(it.chan_id_in);
          if (e >= 0) begin push(ST_OK, it.chan_id_in, e); return; end
          e = free_entry();
          if (e < 0) begin push(ST_BUSY, it.chan_id_in); return; end
          allocate(e, it.chan_id_in, it.now_ms);
          push(ST_OK, it.chan_id_in, e);
        end
        default: begin
          e = lookup(it.chan_id_in);
          if (e < 0) begin push(ST_INVALID_CHAN, it.chan_id_in); return; end
          ent_valid[e] = 0;
          clear_msg(e);
          push(ST_OK, it.chan_id_in, e);
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start_i = 0;
  logic busy_o;
  item_t item_i = '0;
  logic result_valid_o;
  result_t result_o;
  logic cfg_we_i = 0;
  cfg_reg_e cfg_idx_i = CFG_TIMEOUT;
  logic [CFG_W-1:0] cfg_data_i = '0;

  reassembly_scoreboard sb;
  longint cycles = 0;
  logic [31:0] clock_ms = 0;
  logic [31:0] known_ids[NCH];

  hid_frame_reassembly_controller_core dut (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && result_valid_o) sb.check_result(result_o);
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int gap_len();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    return n;
  endfunction

  // start_i stays high after an accept when the next word follows at once.
  task automatic send_word(item_t it);
    int n;
    n = gap_len();
    if (n > 0) begin
      start_i <= 0;
      repeat (n) @(posedge clk_i);
    end
    item_i <= it;
    start_i <= 1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_input(it);
  endtask

  task automatic drain();
    start_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned val);
    drain();
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (idx == CFG_TIMEOUT) sb.timeout_ms = val & 16'hFFFF;
    else sb.max_len = val & 13'h1FFF;
  endtask

  function automatic item_t make(mode_e m, logic [31:0] cid, logic [7:0] cb = 0,
                                 logic [15:0] len = 0);
    item_t it;
    it.mode = m; it.chan_id_in = cid; it.cmd_or_seq = cb; it.len_field = len;
    it.now_ms = clock_ms;
    return it;
  endfunction

  // A whole message on one channel: initial frame then in-order continuations.
  task automatic send_message(logic [31:0] cid, int unsigned len);
    int nframes;
    clock_ms += $urandom_range(0, 50);
    send_word(make(MODE_FRAME, cid, {1'b1, 7'($urandom)}, len));
    nframes = (len > INIT_PAYLOAD) ? (len - INIT_PAYLOAD + CONT_PAYLOAD - 1) / CONT_PAYLOAD : 0;
    for (int s = 0; s < nframes; s++) begin
      clock_ms += $urandom_range(0, 20);
      if ($urandom_range(0, 30) == 0) clock_ms += $urandom_range(500, 70000);
      send_word(make(MODE_FRAME, cid,
                     ($urandom_range(0, 25) == 0) ? 8'($urandom) : 8'(s), 16'($urandom)));
    end
  endtask

  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return BCAST_ID;
      2: return $urandom;
      default: return known_ids[$urandom_range(0, NCH - 1)];
    endcase
  endfunction

  task automatic random_word();
    item_t it;
    it = '0;
    it.mode = 2'($urandom_range(0, 3));
    it.chan_id_in = pick_id();
    it.cmd_or_seq = 8'($urandom);
    it.len_field = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 200));
    clock_ms += ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 300);
    it.now_ms = clock_ms;
    send_word(it);
  endtask

  initial begin
    sb = new();
    sb.init();
    for (int i = 0; i < NCH; i++) known_ids[i] = 32'h1000 + i;
    known_ids[NCH - 1] = 32'hFFFF_FFFE;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: reserved and broadcast ids, table full, length limits, resync, timeout, close.
    send_word(make(MODE_FRAME, 32'h0, 8'h86, 16'd10));
    send_word(make(MODE_FRAME, 32'h1234, 8'h86, 16'd10));
    send_word(make(MODE_OPEN, 32'h0));
    send_word(make(MODE_OPEN, BCAST_ID));
    send_word(make(MODE_FRAME, BCAST_ID, 8'h01, 16'd0));
    send_message(BCAST_ID, 8);
    for (int i = 0; i < NCH; i++) send_word(make(MODE_OPEN, known_ids[i]));
    send_word(make(MODE_OPEN, known_ids[1]));
    send_word(make(MODE_OPEN, 32'h5555));
    send_word(make(MODE_FRAME, BCAST_ID, 8'h86, 16'd4));
    send_word(make(MODE_FRAME, known_ids[0], 8'hFF, 16'hFFFF));
    send_word(make(MODE_FRAME, known_ids[0], 8'h80, 16'd7610));
    send_word(make(MODE_FRAME, known_ids[1], 8'h81, 16'd0));
    send_message(known_ids[0], 7609);
    send_word(make(MODE_FRAME, known_ids[2], 8'h90, 16'd200));
    send_word(make(MODE_FRAME, known_ids[2], 8'h05, 16'd0));
    send_word(make(MODE_FRAME, known_ids[2], 8'hBC, 16'd59));
    clock_ms += 601;
    send_word(make(MODE_TICK, 32'h0));
    send_word(make(MODE_CLOSE, known_ids[3]));
    send_word(make(MODE_CLOSE, known_ids[3]));

    write_reg(CFG_MAX_LEN, 0);
    write_reg(CFG_TIMEOUT, 1);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: begin write_reg(CFG_MAX_LEN, 7609); write_reg(CFG_TIMEOUT, 65535); end
        2: begin write_reg(CFG_MAX_LEN, 300); write_reg(CFG_TIMEOUT, 600); end
        3: begin write_reg(CFG_MAX_LEN, 8191); write_reg(CFG_TIMEOUT, 40); end
        default: ;
      endcase
      for (int k = 0; k < 30; k++) begin
        if ($urandom_range(0, 2) == 0) random_word();
        else begin
          logic [31:0] cid;
          cid = ($urandom_range(0, 7) == 0) ? BCAST_ID : known_ids[$urandom_range(0, NCH - 1)];
          if (cid != BCAST_ID && sb.lookup(cid) < 0) send_word(make(MODE_OPEN, cid));
          send_message(cid, ($urandom_range(0, 12) == 0) ? $urandom_range(0, 8191)
                                                         : $urandom_range(0, 250));
          if ($urandom_range(0, 5) == 0) begin
            clock_ms += $urandom;
            send_word(make(MODE_TICK, 32'($urandom)));
          end
        end
        if (k == 20) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
